FILE: hdl/glyph_serial_display_writer_unit_macros.svh
// Assertion macros for the glyph serial display writer.
`ifndef GLYPH_SERIAL_DISPLAY_WRITER_UNIT_MACROS_SVH
`define GLYPH_SERIAL_DISPLAY_WRITER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GSDW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsdw assertion failed");
`define GSDW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsdw assertion failed");
`else
`define GSDW_ASSERT_NOW(lbl, ante, cons)
`define GSDW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/gsdw_pkg.sv
// Package: request/result types, queue types, kind codes and the 5x7 font ROM.
package gsdw_pkg;

    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;

    localparam logic [7:0] GLYPH_FIRST = 8'h20;
    localparam logic [7:0] GLYPH_LAST  = 8'h7f;

    localparam int GLYPH_BITS = 56;
    localparam int BYTE_BITS  = 8;
    localparam int COL_BITS   = 40;
    localparam int CNT_W      = $clog2(GLYPH_BITS);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic dc_level;
        logic serial_bit;
        logic last;
    } ser_t;

    // queue entry: byte jobs keep the byte in cols[39:32]
    typedef struct packed {
        logic                dc;
        logic                glyph;
        logic [COL_BITS-1:0] cols;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_rd_t;

    function automatic logic [COL_BITS-1:0] font_cols(input logic [6:0] idx);
        logic [COL_BITS-1:0] r;
        case (idx)
            7'd0:  r = 40'h0000000000;
            7'd1:  r = 40'h00005f0000;
            7'd2:  r = 40'h0007000700;
            7'd3:  r = 40'h147f147f14;
            7'd4:  r = 40'h242a7f2a12;
            7'd5:  r = 40'h2313086462;
            7'd6:  r = 40'h3649552250;
            7'd7:  r = 40'h0005030000;
            7'd8:  r = 40'h001c224100;
            7'd9:  r = 40'h0041221c00;
            7'd10: r = 40'h14083e0814;
            7'd11: r = 40'h08083e0808;
            7'd12: r = 40'h0050300000;
            7'd13: r = 40'h0808080808;
            7'd14: r = 40'h0060600000;
            7'd15: r = 40'h2010080402;
            7'd16: r = 40'h3e5149453e;
            7'd17: r = 40'h00427f4000;
            7'd18: r = 40'h4261514946;
            7'd19: r = 40'h2141454b31;
            7'd20: r = 40'h1814127f10;
            7'd21: r = 40'h2745454539;
            7'd22: r = 40'h3c4a494930;
            7'd23: r = 40'h0171090503;
            7'd24: r = 40'h3649494936;
            7'd25: r = 40'h064949291e;
            7'd26: r = 40'h0036360000;
            7'd27: r = 40'h0056360000;
            7'd28: r = 40'h0814224100;
            7'd29: r = 40'h1414141414;
            7'd30: r = 40'h0041221408;
            7'd31: r = 40'h0201510906;
            7'd32: r = 40'h324979413e;
            7'd33: r = 40'h7e1111117e;
            7'd34: r = 40'h7f49494936;
            7'd35: r = 40'h3e41414122;
            7'd36: r = 40'h7f4141221c;
            7'd37: r = 40'h7f49494941;
            7'd38: r = 40'h7f09090901;
            7'd39: r = 40'h3e4149497a;
            7'd40: r = 40'h7f0808087f;
            7'd41: r = 40'h00417f4100;
            7'd42: r = 40'h2040413f01;
            7'd43: r = 40'h7f08142241;
            7'd44: r = 40'h7f40404040;
            7'd45: r = 40'h7f020c027f;
            7'd46: r = 40'h7f0408107f;
            7'd47: r = 40'h3e4141413e;
            7'd48: r = 40'h7f09090906;
            7'd49: r = 40'h3e4151215e;
            7'd50: r = 40'h7f09192946;
            7'd51: r = 40'h4649494931;
            7'd52: r = 40'h01017f0101;
            7'd53: r = 40'h3f4040403f;
            7'd54: r = 40'h1f2040201f;
            7'd55: r = 40'h3f4038403f;
            7'd56: r = 40'h6314081463;
            7'd57: r = 40'h0708700807;
            7'd58: r = 40'h6151494543;
            7'd59: r = 40'h007f414100;
            7'd60: r = 40'h0204081020;
            7'd61: r = 40'h0041417f00;
            7'd62: r = 40'h0402010204;
            7'd63: r = 40'h4040404040;
            7'd64: r = 40'h0001020400;
            7'd65: r = 40'h2054545478;
            7'd66: r = 40'h7f48444438;
            7'd67: r = 40'h3844444420;
            7'd68: r = 40'h384444487f;
            7'd69: r = 40'h3854545418;
            7'd70: r = 40'h087e090102;
            7'd71: r = 40'h0c5252523e;
            7'd72: r = 40'h7f08040478;
            7'd73: r = 40'h00447d4000;
            7'd74: r = 40'h2040443d00;
            7'd75: r = 40'h7f10284400;
            7'd76: r = 40'h00417f4000;
            7'd77: r = 40'h7c04180478;
            7'd78: r = 40'h7c08040478;
            7'd79: r = 40'h3844444438;
            7'd80: r = 40'h7c14141408;
            7'd81: r = 40'h081414187c;
            7'd82: r = 40'h7c08040408;
            7'd83: r = 40'h4854545420;
            7'd84: r = 40'h043f444020;
            7'd85: r = 40'h3c4040207c;
            7'd86: r = 40'h1c2040201c;
            7'd87: r = 40'h3c4030403c;
            7'd88: r = 40'h4428102844;
            7'd89: r = 40'h0c5050503c;
            7'd90: r = 40'h4464544c44;
            7'd91: r = 40'h0008364100;
            7'd92: r = 40'h00007f0000;
            7'd93: r = 40'h0041360800;
            7'd94: r = 40'h1008081008;
            7'd95: r = 40'h0006090906;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/gsdw_front.sv
// Front end: accepts requests, drops unused kinds, does the font lookup, pushes jobs.
module gsdw_front (
    input  gsdw_pkg::item_t item,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic            q_full,
    output gsdw_pkg::q_wr_t q_wr
);
    import gsdw_pkg::*;

    logic       in_range;
    logic [7:0] offset;

    assign in_range   = (item.value >= GLYPH_FIRST) && (item.value <= GLYPH_LAST);
    assign offset     = item.value - GLYPH_FIRST;
    assign item_stall = q_full;

    always_comb
    begin
        q_wr.push      = 1'b0;
        q_wr.job.dc    = 1'b1;
        q_wr.job.glyph = 1'b0;
        q_wr.job.cols  = '0;
        case (item.kind)
            KIND_CMD, KIND_DATA:
            begin
                q_wr.push      = item_valid && !q_full;
                q_wr.job.dc    = item.kind[0];
                q_wr.job.cols  = {item.value, {(COL_BITS-8){1'b0}}};
            end
            KIND_CHAR:
            begin
                q_wr.push      = item_valid && !q_full;
                q_wr.job.glyph = 1'b1;
                if (in_range)
                begin
                    q_wr.job.cols = font_cols(offset[6:0]);
                end
            end
            default:
            begin
                q_wr.push = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/gsdw_queue.sv
// Short job queue between front and back.
module gsdw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  gsdw_pkg::q_wr_t q_wr,
    output logic            q_full,
    input  logic            q_pop,
    output gsdw_pkg::q_rd_t q_rd
);
    import gsdw_pkg::*;

    job_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_pop;

    assign q_full     = (count_reg == Q_CW'(Q_DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.job   = mem_reg[rd_ptr_reg];
    assign do_pop     = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        if (q_wr.push && !do_pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (!q_wr.push && do_pop)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.job;
        end
    end

endmodule

FILE: hdl/gsdw_back.sv
// Back end: serializes jobs MSB first into the registered bit stream.
module gsdw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  gsdw_pkg::q_rd_t q_rd,
    output logic            q_pop,
    output logic            ser_valid,
    input  logic            ser_stall,
    output gsdw_pkg::ser_t  ser
);
    import gsdw_pkg::*;

    logic [GLYPH_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  dc_reg, dc_next;
    logic                  valid_reg, valid_next;
    ser_t                  ser_reg, ser_next;
    logic                  advance;
    logic [GLYPH_BITS-1:0] word;

    assign advance   = !valid_reg || !ser_stall;
    assign ser_valid = valid_reg;
    assign ser       = ser_reg;
    assign word      = q_rd.job.glyph ? {8'h00, q_rd.job.cols, 8'h00}
                                      : {q_rd.job.cols, 16'h0000};

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        dc_next    = dc_reg;
        valid_next = valid_reg;
        ser_next   = ser_reg;
        q_pop      = 1'b0;
        if (advance)
        begin
            if (busy_reg)
            begin
                valid_next = 1'b1;
                ser_next   = '{dc_level: dc_reg, serial_bit: shift_reg[GLYPH_BITS-1],
                               last: (cnt_reg == CNT_W'(1))};
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - CNT_W'(1);
                busy_next  = (cnt_reg != CNT_W'(1));
            end
            else if (q_rd.valid)
            begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                ser_next   = '{dc_level: q_rd.job.dc, serial_bit: word[GLYPH_BITS-1],
                               last: 1'b0};
                shift_next = word << 1;
                cnt_next   = q_rd.job.glyph ? CNT_W'(GLYPH_BITS - 1) : CNT_W'(BYTE_BITS - 1);
                busy_next  = 1'b1;
                dc_next    = q_rd.job.dc;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        dc_reg    <= dc_next;
        ser_reg   <= ser_next;
    end

endmodule

FILE: hdl/glyph_serial_display_writer_unit.sv
// Top level: serial writer for a three-wire display link with 5x7 text rendering.
//
// Request channel (item_valid/item_stall/item): kind 0 sends value as a command
// byte, kind 1 as a display data byte, kind 2 renders value as a character
// (blank column, five font columns, blank column). Kind 3 is taken and dropped.
// Result channel (ser_valid/ser_stall/ser): one result per data line bit, MSB
// first, dc_level alongside, last set on the final bit of each request.
// With the back end idle, a taken request is first written into the job queue,
// and its first bit is then registered in the output stage.
// A byte request sends 8 bits and a character request 56 bits. Bits of
// consecutive requests follow with no gap when the next job is queued, one bit
// per cycle from the back end shifter while ser_stall is low. A two-entry job
// queue lets the front take the next request while the back is still shifting.
// Reset clears the queue and the output stage; no request is pending after it.
// While ser_stall is high the presented bit holds and the shifter waits; the
// front keeps taking requests until the queue is full.
module glyph_serial_display_writer_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  gsdw_pkg::item_t  item,
    output logic             ser_valid,
    input  logic             ser_stall,
    output gsdw_pkg::ser_t   ser
);
    import gsdw_pkg::*;
    `include "glyph_serial_display_writer_unit_macros.svh"

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    gsdw_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    gsdw_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    gsdw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .ser_valid (ser_valid),
        .ser_stall (ser_stall),
        .ser       (ser)
    );

    `GSDW_ASSERT_NOW(a_push_not_full, q_wr.push, !q_full)
    `GSDW_ASSERT_NOW(a_pop_has_job, q_pop, q_rd.valid)
    `GSDW_ASSERT_NEXT(a_no_gap_in_request, ser_valid && !ser.last && !ser_stall, ser_valid)

endmodule

FILE: verif/tb_glyph_serial_display_writer_unit.sv
// Testbench for glyph_serial_display_writer_unit: directed table, random requests, bit checker.
module tb_glyph_serial_display_writer_unit;
    import gsdw_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned DIR_ROWS = 22;
    localparam int unsigned PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 35;
    localparam int unsigned TAIL_CYCLES = 16;

    typedef enum logic [1:0] {PACE_NONE, PACE_LIGHT, PACE_HEAVY} pace_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        typed;
        logic        dc;
        logic [5:0]  nbits;
        logic [55:0] word;
    } dir_row_t;

    // 5x7 font, column 0 in the top byte
    localparam logic [39:0] FONT5X7 [0:95] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0006090906
    };

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   item_valid = 1'b0;
    logic   item_stall;
    item_t  item = '0;
    logic   ser_valid;
    logic   ser_stall = 1'b0;
    ser_t   ser;

    ser_t        line_bits_q [$];
    dir_row_t    dir_rows [0:DIR_ROWS-1];
    pace_t       send_pace = PACE_NONE;
    pace_t       recv_pace = PACE_NONE;
    int unsigned kind_count [0:3] = '{0, 0, 0, 0};
    int unsigned bits_checked = 0;
    int unsigned errors = 0;
    int unsigned stall_left = 0;

    glyph_serial_display_writer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .ser_valid  (ser_valid),
        .ser_stall  (ser_stall),
        .ser        (ser)
    );

    always #10 clk = ~clk;

    initial
    begin
        #60000000;
        $display("[glyph_serial_display_writer_unit] ERROR");
        $finish;
    end

    function automatic int unsigned pick_gap(input pace_t pace);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (pace)
            PACE_LIGHT: return (r < 80) ? 0 : (r < 97) ? $urandom_range(1, 3)
                                                       : $urandom_range(8, 24);
            PACE_HEAVY: return (r < 40) ? 0 : (r < 88) ? $urandom_range(1, 4)
                                                       : $urandom_range(8, 24);
            default:    return 0;
        endcase
    endfunction

    // queue nbits line levels, MSB first, last flag on the final one
    function automatic void push_line_bits(input logic dc, input int nbits,
                                           input logic [55:0] word);
        ser_t s;
        for (int i = nbits - 1; i >= 0; i--)
        begin
            s.dc_level = dc;
            s.serial_bit = word[i];
            s.last = (i == 0);
            line_bits_q.push_back(s);
        end
    endfunction

    function automatic void predict_line_bits(input item_t req);
        logic [39:0] cols;
        cols = '0;
        case (req.kind)
            KIND_CMD:  push_line_bits(1'b0, BYTE_BITS, {48'h0, req.value});
            KIND_DATA: push_line_bits(1'b1, BYTE_BITS, {48'h0, req.value});
            KIND_CHAR:
            begin
                if (req.value >= GLYPH_FIRST && req.value <= GLYPH_LAST)
                    cols = FONT5X7[req.value - GLYPH_FIRST];
                push_line_bits(1'b1, GLYPH_BITS, {8'h00, cols, 8'h00});
            end
            default: ;
        endcase
    endfunction

    task automatic issue_request(input item_t req);
        item <= req;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        kind_count[req.kind]++;
    endtask

    task automatic idle_sender();
        int unsigned n;
        n = pick_gap(send_pace);
        if (n != 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (line_bits_q.size() != 0);
    endtask

    always @(posedge clk)
    begin : stall_gen
        int unsigned n;
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else
        begin
            n = pick_gap(recv_pace);
            if (n != 0)
            begin
                ser_stall <= 1'b1;
                stall_left = n - 1;
            end
            else
                ser_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : line_check
        ser_t want;
        if (rst_n && ser_valid && !ser_stall)
        begin
            bits_checked++;
            if (line_bits_q.size() == 0)
            begin
                $display("%0t: unexpected bit: dc=%b bit=%b last=%b", $time,
                         ser.dc_level, ser.serial_bit, ser.last);
                errors++;
            end
            else
            begin
                want = line_bits_q.pop_front();
                if (ser.dc_level !== want.dc_level)
                begin
                    $display("%0t: dc_level expected %b got %b", $time,
                             want.dc_level, ser.dc_level);
                    errors++;
                end
                if (ser.serial_bit !== want.serial_bit)
                begin
                    $display("%0t: serial_bit expected %b got %b", $time,
                             want.serial_bit, ser.serial_bit);
                    errors++;
                end
                if (ser.last !== want.last)
                begin
                    $display("%0t: last expected %b got %b", $time,
                             want.last, ser.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        item_t       req;
        int unsigned r;
        int unsigned taken;

        //            kind         value  typed dc  nbits word
        dir_rows[0]  = '{KIND_CMD,    8'h00, 1'b1, 1'b0, 6'd8,  56'h00};
        dir_rows[1]  = '{KIND_CMD,    8'hff, 1'b1, 1'b0, 6'd8,  56'hff};
        dir_rows[2]  = '{KIND_DATA,   8'h00, 1'b1, 1'b1, 6'd8,  56'h00};
        dir_rows[3]  = '{KIND_DATA,   8'hff, 1'b1, 1'b1, 6'd8,  56'hff};
        dir_rows[4]  = '{KIND_CMD,    8'ha5, 1'b1, 1'b0, 6'd8,  56'ha5};
        dir_rows[5]  = '{KIND_DATA,   8'h5a, 1'b1, 1'b1, 6'd8,  56'h5a};
        dir_rows[6]  = '{KIND_CHAR,   8'h20, 1'b0, 1'b1, 6'd56, 56'h0};
        dir_rows[7]  = '{KIND_CHAR,   8'h7f, 1'b0, 1'b1, 6'd56, 56'h0};
        dir_rows[8]  = '{KIND_CHAR,   8'h1f, 1'b1, 1'b1, 6'd56, 56'h0};
        dir_rows[9]  = '{KIND_CHAR,   8'h80, 1'b1, 1'b1, 6'd56, 56'h0};
        dir_rows[10] = '{KIND_CHAR,   8'h00, 1'b1, 1'b1, 6'd56, 56'h0};
        dir_rows[11] = '{KIND_CHAR,   8'hff, 1'b1, 1'b1, 6'd56, 56'h0};
        dir_rows[12] = '{KIND_UNUSED, 8'h55, 1'b1, 1'b0, 6'd0,  56'h0};
        dir_rows[13] = '{KIND_UNUSED, 8'haa, 1'b1, 1'b0, 6'd0,  56'h0};
        dir_rows[14] = '{KIND_CMD,    8'h21, 1'b1, 1'b0, 6'd8,  56'h21};
        dir_rows[15] = '{KIND_DATA,   8'h80, 1'b1, 1'b1, 6'd8,  56'h80};
        dir_rows[16] = '{KIND_DATA,   8'h01, 1'b1, 1'b1, 6'd8,  56'h01};
        dir_rows[17] = '{KIND_CHAR,   8'h41, 1'b0, 1'b1, 6'd56, 56'h0};
        dir_rows[18] = '{KIND_CHAR,   8'h67, 1'b0, 1'b1, 6'd56, 56'h0};
        dir_rows[19] = '{KIND_CHAR,   8'h7e, 1'b0, 1'b1, 6'd56, 56'h0};
        dir_rows[20] = '{KIND_CHAR,   8'h30, 1'b0, 1'b1, 6'd56, 56'h0};
        dir_rows[21] = '{KIND_CHAR,   8'h21, 1'b0, 1'b1, 6'd56, 56'h0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        recv_pace <= PACE_HEAVY;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            req.kind = dir_rows[i].kind;
            req.value = dir_rows[i].value;
            issue_request(req);
            if (dir_rows[i].typed)
                push_line_bits(dir_rows[i].dc, int'(dir_rows[i].nbits), dir_rows[i].word);
            else
                predict_line_bits(req);
            if (i == 11)
                drain_results();
        end
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            send_pace = (p == 0) ? PACE_NONE : pace_t'($urandom_range(0, 2));
            recv_pace <= (p == 0) ? PACE_NONE : pace_t'($urandom_range(0, 2));
            if (p % 2 == 1)
                drain_results();
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    req.kind = KIND_UNUSED;
                else if (r < 28)
                    req.kind = KIND_CMD;
                else if (r < 52)
                    req.kind = KIND_DATA;
                else
                    req.kind = KIND_CHAR;
                if (req.kind == KIND_CHAR && $urandom_range(0, 99) < 85)
                    req.value = 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
                else
                    req.value = 8'($urandom_range(0, 255));
                issue_request(req);
                predict_line_bits(req);
                if (req.kind != KIND_UNUSED)
                    taken++;
                idle_sender();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("requests: %0d command, %0d data, %0d character, %0d unused kind",
                 kind_count[KIND_CMD], kind_count[KIND_DATA], kind_count[KIND_CHAR],
                 kind_count[KIND_UNUSED]);
        $display("serial bits compared: %0d, mismatches: %0d", bits_checked, errors);
        if (errors == 0)
            $display("[glyph_serial_display_writer_unit] OK");
        else
            $display("[glyph_serial_display_writer_unit] ERROR");
        $finish;
    end

endmodule
